// File: hdl/stki_pkg.sv
`timescale 1ns / 1ps

package stki_pkg;

    // One stored table entry.
    typedef struct packed {
        logic [15:0] tag;
        logic [14:0] rows;
        logic [30:0] score;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Per-cycle commands broadcast to every cell of the row.
    typedef struct packed {
        logic compare;
        logic commit;
    } cell_ctrl_t;

    // Request payload on s_tdata, highest field first.
    typedef struct packed {
        logic [2:0]  pad;
        logic [6:0]  read_index;
        logic [15:0] name_tag;
        logic [14:0] cleared_rows;
        logic [30:0] new_score;
    } in_item_t;

    // Result payload on m_tdata, highest field first.
    typedef struct packed {
        logic        out_valid;
        logic [15:0] out_tag;
        logic [14:0] out_rows;
        logic [30:0] out_score;
        logic        accepted;
        logic [7:0]  position;
    } out_item_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic [7:0] KEEP_LIMIT_RESET = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_COMMIT,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// File: hdl/sorted_top_k_insert.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tuser: mode; s_tdata: score, rows, tag, index
// m_        out        m_tvalid/m_tready  m_tdata: position, accepted, score, rows, tag, valid
// cfg_      in         cfg_we             cfg_wdata: keep limit
//
// An insert request goes through these steps from acceptance to the next acceptance:
// accept, compare in every cell, shift the row, then load the output register.
// A read request waits while the registered mux tree that selects one cell
// of the row settles, then loads the output register.
// Reset is synchronous and active low; it empties the table and sets the
// keep limit to 100. A stalled result holds the block in its last step.

module sorted_top_k_insert #(
    parameter int CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // new_score, cleared_rows, name_tag, read_index, zero pad
    input  logic [0:0]  s_tuser,   // mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // position, accepted, out_score, out_rows, out_tag, out_valid

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import stki_pkg::*;

    // Widths that follow from the table size.
    localparam int CNTW = $clog2(CAPACITY+1);
    localparam int IDXW = $clog2(CAPACITY);
    localparam int LW   = (CNTW > 8) ? CNTW : 8;
    localparam int RW   = (CNTW > 7) ? CNTW : 7;
    localparam int TW   = $clog2(IDXW+1);

    state_t            state_reg, state_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [7:0]        keep_limit_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    out_item_t         m_tdata_reg, m_tdata_next;

    // Request payload, held for the whole operation.
    logic              req_mode_reg;
    entry_t            req_entry_reg;
    logic [6:0]        req_idx_reg;

    logic [TW-1:0]     wait_reg, wait_next;
    logic [7:0]        position_reg, position_next;
    logic              accepted_reg, accepted_next;

    cell_ctrl_t        ctrl;
    entry_t            cell_entry [CAPACITY];
    logic [ENTRY_W-1:0] leaf_data [CAPACITY];
    logic [CAPACITY-1:0] cell_ge;
    entry_t            read_entry;

    logic [CNTW-1:0]   lim;
    logic [LW-1:0]     limit_ext;
    logic              take;
    logic [IDXW-1:0]   ins_slot;
    logic [CNTW:0]     count_inc;
    logic [CNTW-1:0]   newcount;
    logic [RW-1:0]     idx_ext;
    logic              read_hit;
    out_item_t         result;
    in_item_t          s_item;

    assign s_item = in_item_t'(s_tdata);

    // The working limit is the register clamped to 1..CAPACITY.
    always_comb begin
        limit_ext = LW'(keep_limit_reg);
        if (limit_ext == '0) begin
            lim = CNTW'(1);
        end else if (limit_ext > LW'(CAPACITY)) begin
            lim = CNTW'(CAPACITY);
        end else begin
            lim = CNTW'(limit_ext);
        end
    end

    // The row of cells. Each cell sees its left neighbor's entry and compare
    // flag, so the tail moves one place right in a single commit.
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            if (i == 0) begin : g_first
                stki_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
                    .aclk       (aclk),
                    .ctrl       (ctrl),
                    .count      (count_reg),
                    .lim        (lim),
                    .new_entry  (req_entry_reg),
                    .left_entry (req_entry_reg),
                    .left_ge    (1'b1),
                    .entry      (cell_entry[i]),
                    .ge         (cell_ge[i])
                );
            end else begin : g_rest
                stki_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
                    .aclk       (aclk),
                    .ctrl       (ctrl),
                    .count      (count_reg),
                    .lim        (lim),
                    .new_entry  (req_entry_reg),
                    .left_entry (cell_entry[i-1]),
                    .left_ge    (cell_ge[i-1]),
                    .entry      (cell_entry[i]),
                    .ge         (cell_ge[i])
                );
            end
            assign leaf_data[i] = cell_entry[i];
        end
    endgenerate

    stki_mux_tree #(.N(CAPACITY), .W(ENTRY_W)) u_read_tree (
        .aclk   (aclk),
        .leaves (leaf_data),
        .sel    (idx_ext[IDXW-1:0]),
        .dout   (read_entry)
    );

    // The compare flags form a run of ones from cell 0, because the table
    // stays sorted. The insert lands at the first cleared flag, and it is
    // stored only if that place lies below the working limit.
    always_comb begin
        take     = 1'b0;
        ins_slot = '0;
        for (int c = 0; c < CAPACITY; c++) begin
            if (!cell_ge[c] && (CNTW'(c) < lim)) begin
                take = 1'b1;
            end
            if (!cell_ge[c] && ((c == 0) || cell_ge[(c > 0) ? c - 1 : 0])) begin
                ins_slot = ins_slot | IDXW'(c);
            end
        end
    end

    always_comb begin
        count_inc = (CNTW+1)'(count_reg) + (CNTW+1)'(1);
        if (count_inc > (CNTW+1)'(lim)) begin
            newcount = lim;
        end else begin
            newcount = CNTW'(count_inc);
        end
    end

    assign idx_ext  = RW'(req_idx_reg);
    assign read_hit = idx_ext < RW'(count_reg);

    // Result word for the finished request.
    always_comb begin
        result = '0;
        if (req_mode_reg == MODE_READ) begin
            if (read_hit) begin
                result.out_score = read_entry.score;
                result.out_rows  = read_entry.rows;
                result.out_tag   = read_entry.tag;
                result.out_valid = 1'b1;
            end
        end else begin
            result.position = position_reg;
            result.accepted = accepted_reg;
        end
    end

    // Sequencer: compare, then commit, for an insert; wait out the tree
    // latency for a read; then hand the result to the output register.
    always_comb begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        count_next    = count_reg;
        position_next = position_reg;
        accepted_next = accepted_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ctrl          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    wait_next  = '0;
                    state_next = (s_tuser[0] == MODE_READ) ? ST_READ : ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                ctrl.compare = 1'b1;
                state_next   = ST_COMMIT;
            end
            ST_COMMIT: begin
                accepted_next = take;
                if (take) begin
                    ctrl.commit   = 1'b1;
                    count_next    = newcount;
                    position_next = 8'((IDXW+1)'(ins_slot) + (IDXW+1)'(1));
                end else begin
                    position_next = 8'((CNTW+1)'(lim) + (CNTW+1)'(1));
                end
                state_next = ST_DONE;
            end
            ST_READ: begin
                if (wait_reg == TW'(IDXW - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    wait_next = wait_reg + TW'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            keep_limit_reg <= KEEP_LIMIT_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                keep_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_mode_reg        <= s_tuser[0];
            req_entry_reg.score <= s_item.new_score;
            req_entry_reg.rows  <= s_item.cleared_rows;
            req_entry_reg.tag   <= s_item.name_tag;
            req_idx_reg         <= s_item.read_index;
        end
        wait_reg     <= wait_next;
        position_reg <= position_next;
        accepted_reg <= accepted_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The table never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A stored insert always leaves at least one entry in the table.
    a_commit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> count_reg != '0)
        else $error("table empty after a stored insert");

    // A read never changes the fill count.
    a_read_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> $stable(count_reg))
        else $error("entry count changed during a read");

    // A new result appears only out of the final step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

endmodule

// File: hdl/stki_cell.sv
`timescale 1ns / 1ps

module stki_cell #(
    parameter int CAPACITY = 128,
    parameter int INDEX    = 0
) (
    input  logic                             aclk,
    input  stki_pkg::cell_ctrl_t             ctrl,
    input  logic [$clog2(CAPACITY+1)-1:0]    count,
    input  logic [$clog2(CAPACITY+1)-1:0]    lim,
    input  stki_pkg::entry_t                 new_entry,
    input  stki_pkg::entry_t                 left_entry,
    input  logic                             left_ge,
    output stki_pkg::entry_t                 entry,
    output logic                             ge
);
    import stki_pkg::*;

    localparam int CNTW = $clog2(CAPACITY+1);

    entry_t entry_reg, entry_next;
    logic   ge_reg, ge_next;
    logic   occupied;
    logic   in_window;

    always_comb begin
        occupied  = CNTW'(INDEX) < count;
        in_window = CNTW'(INDEX) < lim;

        ge_next = ge_reg;
        if (ctrl.compare) begin
            ge_next = occupied && (entry_reg.score >= new_entry.score);
        end

        // A cell that holds a score at least as large keeps its entry; the
        // first smaller cell takes the new one, the rest below the limit take the left one.
        entry_next = entry_reg;
        if (ctrl.commit && in_window && !ge_reg) begin
            entry_next = left_ge ? new_entry : left_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        ge_reg    <= ge_next;
    end

    assign entry = entry_reg;
    assign ge    = ge_reg;

endmodule

// File: hdl/stki_mux_tree.sv
`timescale 1ns / 1ps

module stki_mux_tree #(
    parameter int N = 128,
    parameter int W = 62
) (
    input  logic                                 aclk,
    input  logic [W-1:0]                         leaves [N],
    input  logic [((N > 1) ? $clog2(N) : 1)-1:0] sel,
    output logic [W-1:0]                         dout
);
    localparam int LVL = (N > 1) ? $clog2(N) : 1;
    localparam int P   = 1 << LVL;

    logic [W-1:0] leaf_pad [P];
    logic [W-1:0] node_reg [1:P-1];

    genvar j, k;
    generate
        for (j = 0; j < P; j++) begin : g_leaf
            if (j < N) begin : g_real
                assign leaf_pad[j] = leaves[j];
            end else begin : g_zero
                assign leaf_pad[j] = '0;
            end
        end

        // Heap order: node k has children 2k and 2k+1; every node is a register.
        for (k = 1; k < P; k++) begin : g_node
            localparam int D = $clog2(k + 1) - 1;
            if (2 * k >= P) begin : g_bottom
                always_ff @(posedge aclk) begin
                    node_reg[k] <= sel[LVL-1-D] ? leaf_pad[2*k+1-P] : leaf_pad[2*k-P];
                end
            end else begin : g_inner
                always_ff @(posedge aclk) begin
                    node_reg[k] <= sel[LVL-1-D] ? node_reg[2*k+1] : node_reg[2*k];
                end
            end
        end
    endgenerate

    assign dout = node_reg[1];

endmodule
